// ===== sv/tmbvc_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and codes for the triple mask bit vote counter
package tmbvc_pkg;

  localparam int unsigned WORD_BITS  = 64;   // bits per bitmap word, counters per row
  localparam int unsigned COL_BITS   = 6;    // bit position inside a word
  localparam int unsigned WIDX_BITS  = 6;    // word_index width
  localparam int unsigned CIDX_BITS  = 12;   // counter_index width
  localparam int unsigned COUNT_BITS = 8;    // count_value width
  localparam int unsigned MAX_ROWS   = 64;   // rows reachable through a 6-bit word index

  localparam logic OP_ACC  = 1'b0;
  localparam logic OP_READ = 1'b1;

endpackage

// ===== sv/tmbvc_row_mem.sv =====
`timescale 1ns / 1ps
// counter row memory: one row of packed counters per bitmap word, with per-row valid bits
module tmbvc_row_mem #(
  parameter int unsigned Rows  = 64,
  parameter int unsigned AddrW = 6,
  parameter int unsigned DataW = 512
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [DataW-1:0] rd_data_o,
  output logic             rd_valid_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i
);

  logic [DataW-1:0] mem_q [Rows];
  logic [DataW-1:0] rd_data_q;
  logic [Rows-1:0]  valid_q;
  logic             rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // a row never written since reset reads with rd_valid_o low
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o  = rd_data_q;
  assign rd_valid_o = rd_valid_q;

endmodule

// ===== sv/tmbvc_row_update.sv =====
`timescale 1ns / 1ps
// adds one to every counter of a row whose hit bit is set, wrapping per counter
module tmbvc_row_update #(
  parameter int unsigned CounterBits = 8
) (
  input  logic [tmbvc_pkg::WORD_BITS*CounterBits-1:0] row_i,
  input  logic [tmbvc_pkg::WORD_BITS-1:0]             hits_i,
  output logic [tmbvc_pkg::WORD_BITS*CounterBits-1:0] row_o
);

  for (genvar l = 0; l < tmbvc_pkg::WORD_BITS; l++) begin : g_lane
    assign row_o[l*CounterBits +: CounterBits] =
      row_i[l*CounterBits +: CounterBits] + CounterBits'(hits_i[l]);
  end

endmodule

// ===== sv/triple_mask_bit_vote_counter_core.sv =====
`timescale 1ns / 1ps
// top level: per-bit vote counters kept in a row memory, read-modify-write with forwarding
//
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------------------
//  in      | in_valid_i / in_ready_o | op_i, word_index_i, mask_a/b/c_i, counter_index_i
//  out     | out_valid_o / out_ready_i | count_value_o (only for read items)
//
// one item per cycle unless a read item stalls: the row is read at the accepting edge, updated
// and written back in the next cycle; a row written by the item just before is forwarded from a register.
// a read result passes from the modify stage into the output register.
// reset clears per-row valid bits at once, so no clearing pass is needed.
// a read item held by a full output register stalls the input for as long as it waits.
module triple_mask_bit_vote_counter_core #(
  parameter int unsigned NUM_WORDS    = 64,
  parameter int unsigned COUNTER_BITS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             op_i,
  input  logic [tmbvc_pkg::WIDX_BITS-1:0]  word_index_i,
  input  logic [tmbvc_pkg::WORD_BITS-1:0]  mask_a_i,
  input  logic [tmbvc_pkg::WORD_BITS-1:0]  mask_b_i,
  input  logic [tmbvc_pkg::WORD_BITS-1:0]  mask_c_i,
  input  logic [tmbvc_pkg::CIDX_BITS-1:0]  counter_index_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [tmbvc_pkg::COUNT_BITS-1:0] count_value_o
);

  localparam int unsigned Rows  = (NUM_WORDS < tmbvc_pkg::MAX_ROWS) ? NUM_WORDS
                                                                      : tmbvc_pkg::MAX_ROWS;
  localparam int unsigned AddrW = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int unsigned RowW  = tmbvc_pkg::WORD_BITS * COUNTER_BITS;
  localparam int unsigned NumCounters = NUM_WORDS * tmbvc_pkg::WORD_BITS;

  logic                             in_fire;
  logic                             in_range;
  logic [tmbvc_pkg::WIDX_BITS-1:0]  in_row_full;
  logic [AddrW-1:0]                 in_row;

  logic                             s1_valid_q;
  logic                             s1_op_q;
  logic                             s1_range_q;
  logic [AddrW-1:0]                 s1_row_q;
  logic [tmbvc_pkg::WORD_BITS-1:0]  s1_hits_q;
  logic [tmbvc_pkg::COL_BITS-1:0]   s1_col_q;
  logic                             s1_adv;
  logic                             s1_write;

  logic                             fwd_q, fwd_d;
  logic [RowW-1:0]                  fwd_data_q;

  logic [RowW-1:0]                  rd_data;
  logic                             rd_valid;
  logic [RowW-1:0]                  row_cur;
  logic [RowW-1:0]                  row_new;
  logic [COUNTER_BITS-1:0]          cnt_sel;
  logic [31:0]                      cnt_wide;

  logic                             out_valid_q;
  logic [tmbvc_pkg::COUNT_BITS-1:0] count_q, count_d;

  // --- input side
  assign in_fire     = in_valid_i && in_ready_o;
  assign in_row_full = (op_i == tmbvc_pkg::OP_ACC)
                       ? word_index_i
                       : counter_index_i[tmbvc_pkg::CIDX_BITS-1 -: tmbvc_pkg::WIDX_BITS];
  assign in_row      = in_row_full[AddrW-1:0];
  assign in_range    = (op_i == tmbvc_pkg::OP_ACC) ? (32'(word_index_i) < NUM_WORDS)
                                                   : (32'(counter_index_i) < NumCounters);

  assign s1_adv     = s1_valid_q && ((s1_op_q == tmbvc_pkg::OP_ACC) || !out_valid_q ||
                                     out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign s1_write   = s1_adv && (s1_op_q == tmbvc_pkg::OP_ACC) && s1_range_q;

  // the row being written this cycle is what the next item must see
  assign fwd_d = in_fire && s1_write && (s1_row_q == in_row);

  tmbvc_row_mem #(
    .Rows  (Rows),
    .AddrW (AddrW),
    .DataW (RowW)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_fire),
    .rd_addr_i  (in_row),
    .rd_data_o  (rd_data),
    .rd_valid_o (rd_valid),
    .wr_en_i    (s1_write),
    .wr_addr_i  (s1_row_q),
    .wr_data_i  (row_new)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= fwd_d;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
        fwd_q      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q    <= op_i;
      s1_range_q <= in_range;
      s1_row_q   <= in_row;
      s1_hits_q  <= mask_a_i & mask_b_i & mask_c_i;
      s1_col_q   <= counter_index_i[tmbvc_pkg::COL_BITS-1:0];
      fwd_data_q <= row_new;
    end
  end

  // --- modify stage
  assign row_cur = fwd_q ? fwd_data_q : (rd_valid ? rd_data : '0);

  tmbvc_row_update #(
    .CounterBits (COUNTER_BITS)
  ) u_update (
    .row_i  (row_cur),
    .hits_i (s1_hits_q),
    .row_o  (row_new)
  );

  assign cnt_sel  = row_cur[s1_col_q*COUNTER_BITS +: COUNTER_BITS];
  assign cnt_wide = 32'(cnt_sel);
  assign count_d  = s1_range_q ? cnt_wide[tmbvc_pkg::COUNT_BITS-1:0] : '0;

  // --- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv && (s1_op_q == tmbvc_pkg::OP_READ)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && (s1_op_q == tmbvc_pkg::OP_READ)) begin
      count_q <= count_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign count_value_o = count_q;

  // --- checks
  a_read_stall_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && (s1_op_q == tmbvc_pkg::OP_READ) && out_valid_q && !out_ready_i)
      |-> !in_ready_o)
    else $error("input taken while a read item waits for the output register");

  a_fwd_only_with_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> s1_valid_q)
    else $error("forwarded row present without an item in the modify stage");

  a_read_reaches_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (op_i == tmbvc_pkg::OP_READ)) |=> (s1_valid_q && (s1_op_q == tmbvc_pkg::OP_READ)))
    else $error("accepted read item did not enter the modify stage");

  a_no_write_on_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && (s1_op_q == tmbvc_pkg::OP_READ)) |-> !s1_write)
    else $error("read item wrote the counter memory");

endmodule
